// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/mmqf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmqf_pkg
// Types, constants and helper functions of the MIDI message queue filter.
// ----------------------------------------------------------------------------
package mmqf_pkg;

	// Queue geometry. A store entry holds the message with its valid mark on top.
	localparam int QUEUE_DEPTH = 4096;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int MSG_W       = 24;
	localparam int ENTRY_W     = MSG_W + 1;

	// Command codes.
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Status byte landmarks.
	localparam logic [7:0] ST_CHANNEL_MIN = 8'h80;
	localparam logic [7:0] ST_SYSTEM_MIN  = 8'hF0;
	localparam logic [7:0] ST_CLOCK       = 8'hF8;
	localparam logic [7:0] ST_START       = 8'hFA;
	localparam logic [7:0] ST_CONTINUE    = 8'hFB;
	localparam logic [7:0] ST_STOP        = 8'hFC;
	localparam logic [7:0] ST_RESET       = 8'hFF;

	// Data bytes that follow a status, by status nibble 0x8 to 0xF.
	localparam logic [1:0] DATA_LEN [8] = '{2'd2, 2'd2, 2'd2, 2'd2,
		2'd1, 2'd1, 2'd2, 2'd0};

	// Command beat payload.
	typedef struct packed {
		logic       command;
		logic [7:0] status_byte;
		logic [7:0] first_data;
		logic [7:0] second_data;
		logic [5:0] byte_budget;
	} cmd_t;

	// Result beat payload.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [5:0] byte_total;
		logic       last;
	} res_t;

	// Request from the controller to the output register.
	typedef struct packed {
		logic push;
		res_t data;
	} push_t;

	// Whether a stored status passes the read filter.
	function automatic logic status_accepted(input logic [7:0] st);
		logic ok;
		if (st < ST_CHANNEL_MIN) begin
			ok = 1'b0;
		end else if (st >= ST_SYSTEM_MIN) begin
			ok = (st == ST_CLOCK) || (st == ST_START) || (st == ST_CONTINUE) ||
				(st == ST_STOP) || (st == ST_RESET);
		end else begin
			ok = 1'b1;
		end
		return ok;
	endfunction

	// Total message length in bytes, status included.
	function automatic logic [1:0] msg_length(input logic [7:0] st);
		return DATA_LEN[st[6:4]] + 2'd1;
	endfunction

endpackage

// ===== rtl/core/mmqf_ifs.sv =====
// ----------------------------------------------------------------------------
// mmqf_ifs
// Valid/ready channel interfaces for command and result beats.
// ----------------------------------------------------------------------------

// Command channel.
interface mmqf_cmd_if import mmqf_pkg::*;;
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface mmqf_res_if import mmqf_pkg::*;;
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/midi_message_queue_filter.sv =====
// ----------------------------------------------------------------------------
// midi_message_queue_filter
// Ring of three-byte MIDI messages with a filtering, budgeted read-out.
//
//   Channel | Role   | Beat
//   --------+--------+-----------------------------------------------------
//   cmd     | sink   | put a message, or read with a byte budget
//   res     | source | one emitted byte; last beat of a read carries total
//
// A put writes the store as it is taken. A read starts from idle, then each
// stored entry examined is read and decoded (the entry that ends the walk
// included), each emitted byte is sequenced in turn and a closing beat ends
// it; the single read port sets this. Each entry carries its own valid mark,
// so after reset a clearing pass over all 4096 entries empties the store
// before commands go in. A stalled result sink holds the byte sequencer;
// commands wait until the read in progress has handed over its last beat.
// ----------------------------------------------------------------------------
module midi_message_queue_filter import mmqf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mmqf_cmd_if.sink   cmd,
	mmqf_res_if.source res
);

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [PTR_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               out_free;
	push_t              push;

	// Queue controller.
	mmqf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_free  (out_free),
		.push      (push)
	);

	// Message store with valid marks.
	mmqf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result output register.
	mmqf_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.free   (out_free),
		.res    (res)
	);

endmodule

// ===== rtl/core/mmqf_ram.sv =====
// ----------------------------------------------------------------------------
// mmqf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mmqf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/mmqf_out_reg.sv =====
// ----------------------------------------------------------------------------
// mmqf_out_reg
// Output register for result beats; frees itself as the sink takes a beat.
// ----------------------------------------------------------------------------
module mmqf_out_reg import mmqf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       free,
	mmqf_res_if.source res
);

	logic valid_q;
	res_t data_q;

	// A new beat may enter when the register is empty or being drained.
	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.push) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (push.push) begin
			data_q <= push.data;
		end
	end

	assign res.valid = valid_q;
	assign res.data  = data_q;

endmodule

// ===== rtl/core/mmqf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmqf_ctrl
// Queue controller: pointers, clearing pass, read walk and byte sequencing.
// ----------------------------------------------------------------------------
module mmqf_ctrl import mmqf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	mmqf_cmd_if.sink           cmd,
	output logic               ram_we,
	output logic [PTR_W-1:0]   ram_waddr,
	output logic [ENTRY_W-1:0] ram_wdata,
	output logic               ram_re,
	output logic [PTR_W-1:0]   ram_raddr,
	input  logic [ENTRY_W-1:0] ram_rdata,
	input  logic               out_free,
	output push_t              push
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FETCH  = 3'd1;
	localparam logic [2:0] ST_EVAL   = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [2:0]       state_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [5:0]       budget_q;
	logic [5:0]       total_q;
	logic [MSG_W-1:0] msg_q;
	logic [1:0]       len_q;
	logic [1:0]       idx_q;
	logic             hold_v_q;
	logic [7:0]       hold_byte_q;

	logic             accept;
	logic [7:0]       rd_status;
	logic             rd_valid;
	logic             rd_ok;
	logic [1:0]       rd_len;
	logic             rd_fit;
	logic             consume;
	logic             take;
	logic [7:0]       emit_byte;
	logic             emit_go;
	logic [PTR_W-1:0] wp_next;
	logic [PTR_W-1:0] rp_next;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// Ring pointer successors.
	assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;

	// Decode of the fetched entry.
	assign rd_valid  = ram_rdata[MSG_W];
	assign rd_status = ram_rdata[23:16];
	assign rd_ok     = status_accepted(rd_status);
	assign rd_len    = msg_length(rd_status);
	assign rd_fit    = ({4'b0, rd_len} <= budget_q);

	// A valid entry is consumed when it is dropped or when it fits the budget.
	assign consume = (state_q == ST_EVAL) && rd_valid && (!rd_ok || rd_fit);
	assign take    = consume && rd_ok;

	// Store writes: clearing pass, put with its valid mark, and consumption.
	assign ram_we    = (state_q == ST_CLEAR) || consume ||
		(accept && (cmd.data.command == CMD_PUT));
	assign ram_waddr = (state_q == ST_EVAL) ? rp_q : wp_q;
	assign ram_wdata = accept ? {1'b1, cmd.data.status_byte, cmd.data.first_data,
		cmd.data.second_data} : '0;

	// Fetch the entry under the read pointer.
	assign ram_re    = (state_q == ST_FETCH);
	assign ram_raddr = rp_q;

	// Byte of the current message under the index.
	always_comb begin
		case (idx_q)
			2'd0:    emit_byte = msg_q[23:16];
			2'd1:    emit_byte = msg_q[15:8];
			default: emit_byte = msg_q[7:0];
		endcase
	end

	// A byte moves into the hold slot once the held one can leave.
	assign emit_go = (state_q == ST_EMIT) && (!hold_v_q || out_free);

	// Result beats: held bytes go out as the next byte arrives or at the end.
	always_comb begin
		push = '0;
		if (emit_go && hold_v_q) begin
			push.push            = 1'b1;
			push.data.out_byte   = hold_byte_q;
			push.data.byte_valid = 1'b1;
		end else if ((state_q == ST_FINISH) && out_free) begin
			push.push            = 1'b1;
			push.data.out_byte   = hold_v_q ? hold_byte_q : 8'h00;
			push.data.byte_valid = hold_v_q;
			push.data.byte_total = total_q;
			push.data.last       = 1'b1;
		end
	end

	// Sequencer and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			wp_q     <= '0;
			rp_q     <= '0;
			hold_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					wp_q <= wp_next;
					if (wp_q == PTR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (cmd.data.command == CMD_PUT) begin
							wp_q <= wp_next;
						end else begin
							hold_v_q <= 1'b0;
							state_q  <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!rd_valid) begin
						state_q <= ST_FINISH;
					end else if (!rd_ok) begin
						rp_q    <= rp_next;
						state_q <= ST_FETCH;
					end else if (!rd_fit) begin
						state_q <= ST_FINISH;
					end else begin
						rp_q    <= rp_next;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						hold_v_q <= 1'b1;
						if (idx_q == len_q - 2'd1) begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-read working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			budget_q <= cmd.data.byte_budget;
			total_q  <= '0;
		end
		if (take) begin
			msg_q    <= ram_rdata[MSG_W-1:0];
			len_q    <= rd_len;
			idx_q    <= 2'd0;
			budget_q <= budget_q - {4'b0, rd_len};
			total_q  <= total_q + {4'b0, rd_len};
		end
		if (emit_go) begin
			hold_byte_q <= emit_byte;
			idx_q       <= idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/core/mmqf_checker.sv =====
// ----------------------------------------------------------------------------
// mmqf_checker
// Port-level checks on the result channel of the queue filter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmqf_checker import mmqf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res_data
);

	// A stalled result beat holds its value.
	`ASSERT_CLK(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_data), "result beat changed while stalled")

	// Only the closing beat of a read reports a total; all others carry a byte.
	`ASSERT_CLK(a_mid_beat, res_valid && !res_data.last |-> res_data.byte_valid && (res_data.byte_total == 6'd0), "non-last beat malformed")

	// An empty beat is the lone closing beat of an empty read.
	`ASSERT_CLK(a_empty_beat, res_valid && !res_data.byte_valid |-> res_data.last && (res_data.byte_total == 6'd0) && (res_data.out_byte == 8'h00), "empty beat malformed")

	// A command taken while no result is pending yields no result at once.
	`ASSERT_CLK(a_no_early_res, cmd_valid && cmd_ready && !res_valid |=> !res_valid, "result too soon after command")

	// No result is shown during reset.
	`ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !res_valid, "result valid during reset")

endmodule

bind midi_message_queue_filter mmqf_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
